// ===== hw/rtl/bcc_pkg.sv =====
package bcc_pkg;

   localparam int unsigned MAX_BLOCK = 4096;
   localparam int unsigned BLOCK_W = 13;
   localparam int unsigned CRC_W = 32;
   localparam logic [CRC_W-1:0] CRC_POLY = 32'h04C1_1DB7;
   localparam logic [BLOCK_W-1:0] BLOCK_SIZE_RESET = 13'd512;
   localparam logic [BLOCK_W-1:0] BLOCK_MAX = BLOCK_W'(MAX_BLOCK);

   typedef enum logic [1:0] {
      CSR_BLOCK_SIZE = 2'd0,
      CSR_EXPECTED   = 2'd1,
      CSR_START      = 2'd2
   } csr_index_type;

   // one queued input transaction
   typedef struct packed {
      logic [7:0] data_byte;
      logic       final_byte;
   } item_type;

   // configuration seen by the CRC engine
   typedef struct packed {
      logic [BLOCK_W-1:0] block_size;
      logic [CRC_W-1:0]   expected_crc;
      logic [CRC_W-1:0]   start_value;
      logic               start_load;   // start_value written this cycle
   } cfg_type;

   // byte-wide MSB-first CRC update, an XOR network after synthesis
   function automatic logic [CRC_W-1:0] fold_byte(logic [CRC_W-1:0] crc,
                                                  logic [7:0] data);
      logic [CRC_W-1:0] r;
      r = crc ^ {data, 24'd0};
      for (int k = 0; k < 8; k++) begin
         if (r[CRC_W-1]) begin
            r = {r[CRC_W-2:0], 1'b0} ^ CRC_POLY;
         end else begin
            r = {r[CRC_W-2:0], 1'b0};
         end
      end
      return r;
   endfunction

endpackage

// ===== hw/rtl/blockwise_crc32_check.sv =====
// Channel   Ports        Transaction payload
// --------  -----------  ------------------------------------------------------
// request   req_t*       tdata[7:0] data_byte, tlast final_byte
// response  rsp_t*       tdata[31:0] crc_value, tuser[0] crc_matches
// config    csr_*        csr_index register, csr_data value (ready tied high)
//
// One byte per clock sustained unless a final byte waits on a stalled response:
// the CRC engine folds a whole byte through a combinational XOR network, so the
// engine loop is the only per-byte step; the engine registers the response.
// Reset is synchronous, active high; clears queue, CRC state and config to
// block_size 512, expected_crc 0, start_value 0.
// A stalled response holds only final bytes and the bytes queued behind them.
module blockwise_crc32_check (
   input  logic        clock,
   input  logic        reset,
   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // [7:0] data_byte
   input  logic        req_tlast,    // final_byte
   // response stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,    // [31:0] crc_value
   output logic [0:0]  rsp_tuser,    // [0] crc_matches
   // register writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);

   // configuration registers
   logic [bcc_pkg::BLOCK_W-1:0] block_size_ff, block_size_in;
   logic [bcc_pkg::CRC_W-1:0]   expected_ff, expected_in;
   logic [bcc_pkg::CRC_W-1:0]   start_ff, start_in;
   logic                        csr_write;
   logic                        start_load;

   bcc_pkg::item_type in_item;
   bcc_pkg::item_type q_item;
   bcc_pkg::cfg_type  cfg;
   logic              q_valid;
   logic              q_pop;
   logic              match;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_comb begin
      block_size_in = block_size_ff;
      expected_in   = expected_ff;
      start_in      = start_ff;
      start_load    = 1'b0;
      if (csr_write) begin
         case (csr_index)
            bcc_pkg::CSR_BLOCK_SIZE: begin
               block_size_in = csr_data[bcc_pkg::BLOCK_W-1:0];
            end
            bcc_pkg::CSR_EXPECTED: begin
               expected_in = csr_data;
            end
            bcc_pkg::CSR_START: begin
               start_in   = csr_data;
               start_load = 1'b1;
            end
            default: begin
               // unknown index: write dropped
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         block_size_ff <= bcc_pkg::BLOCK_SIZE_RESET;
         expected_ff   <= '0;
         start_ff      <= '0;
      end else begin
         block_size_ff <= block_size_in;
         expected_ff   <= expected_in;
         start_ff      <= start_in;
      end
   end

   // start_load carries the new value straight in so an idle engine reloads now
   assign cfg.block_size   = block_size_ff;
   assign cfg.expected_crc = expected_ff;
   assign cfg.start_value  = start_load ? start_in : start_ff;
   assign cfg.start_load   = start_load;

   assign in_item.data_byte  = req_tdata;
   assign in_item.final_byte = req_tlast;

   bcc_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .in_item  (in_item),
      .q_valid  (q_valid),
      .q_item   (q_item),
      .q_pop    (q_pop)
   );

   bcc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_crc   (rsp_tdata),
      .out_match (match)
   );

   assign rsp_tuser[0] = match;

endmodule

// ===== hw/rtl/bcc_front.sv =====
module bcc_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  bcc_pkg::item_type  in_item,
   output logic               q_valid,
   output bcc_pkg::item_type  q_item,
   input  logic               q_pop
);

   // two-entry queue between the stream input and the CRC engine
   bcc_pkg::item_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   logic       pop;

   assign in_ready = (count_ff != 2'd2);
   assign q_valid  = (count_ff != 2'd0);
   assign q_item   = entry_ff[rd_ptr_ff];

   assign push = in_valid && in_ready;
   assign pop  = q_pop && q_valid;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_item;
      end
   end

endmodule

// ===== hw/rtl/bcc_back.sv =====
module bcc_back (
   input  logic                        clock,
   input  logic                        reset,
   input  bcc_pkg::cfg_type            cfg,
   input  logic                        q_valid,
   input  bcc_pkg::item_type           q_item,
   output logic                        q_pop,
   output logic                        out_valid,
   input  logic                        out_ready,
   output logic [bcc_pkg::CRC_W-1:0]   out_crc,
   output logic                        out_match
);

   logic [bcc_pkg::CRC_W-1:0]   crc_ff, crc_in;
   logic [bcc_pkg::BLOCK_W-1:0] cnt_ff, cnt_in;
   logic                        started_ff, started_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [bcc_pkg::CRC_W-1:0]   rsp_crc_ff, rsp_crc_in;
   logic                        rsp_match_ff, rsp_match_in;

   logic [bcc_pkg::BLOCK_W-1:0] limit;
   logic [bcc_pkg::BLOCK_W-1:0] cnt_next;
   logic [bcc_pkg::CRC_W-1:0]   folded;
   logic [bcc_pkg::CRC_W-1:0]   crc_post;
   logic                        blk_end;
   logic                        take;

   // zero acts as one, oversize clamps to the maximum block
   always_comb begin
      limit = cfg.block_size;
      if (cfg.block_size == '0) begin
         limit = bcc_pkg::BLOCK_W'(1);
      end else if (cfg.block_size > bcc_pkg::BLOCK_MAX) begin
         limit = bcc_pkg::BLOCK_MAX;
      end
   end

   // a final byte needs the result register free
   assign q_pop = q_valid && (!q_item.final_byte || !rsp_valid_ff || out_ready);
   assign take  = q_pop;

   assign folded   = bcc_pkg::fold_byte(crc_ff, q_item.data_byte);
   assign cnt_next = cnt_ff + bcc_pkg::BLOCK_W'(1);
   assign blk_end  = (cnt_next >= limit);
   assign crc_post = (blk_end || q_item.final_byte) ? ~folded : folded;

   always_comb begin
      crc_in       = crc_ff;
      cnt_in       = cnt_ff;
      started_in   = started_ff;
      rsp_valid_in = rsp_valid_ff && !out_ready;
      rsp_crc_in   = rsp_crc_ff;
      rsp_match_in = rsp_match_ff;
      if (cfg.start_load && !started_ff) begin
         crc_in = cfg.start_value;
      end
      if (take) begin
         if (q_item.final_byte) begin
            rsp_valid_in = 1'b1;
            rsp_crc_in   = crc_post;
            rsp_match_in = (crc_post == cfg.expected_crc);
            crc_in       = cfg.start_value;
            cnt_in       = '0;
            started_in   = 1'b0;
         end else begin
            crc_in     = crc_post;
            cnt_in     = blk_end ? '0 : cnt_next;
            started_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff       <= '0;
         cnt_ff       <= '0;
         started_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         crc_ff       <= crc_in;
         cnt_ff       <= cnt_in;
         started_ff   <= started_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_crc_ff   <= rsp_crc_in;
      rsp_match_ff <= rsp_match_in;
   end

   assign out_valid = rsp_valid_ff;
   assign out_crc   = rsp_crc_ff;
   assign out_match = rsp_match_ff;

endmodule

// ===== verif/blockwise_crc32_check_tb.sv =====
`timescale 1ns / 1ps

module blockwise_crc32_check_tb;
   import bcc_pkg::*;

   localparam int CLK_PERIOD = 20;
   localparam int RESET_CYCLES = 9;
   // slack after the last response before registers are touched
   localparam int SETTLE_CYCLES = 4;
   localparam int IDLE_PCT = 28;
   localparam int RANDOM_BYTES = 500;
   // one long image under the clamped block size: no block end inside it
   localparam int LONG_IMAGE_BYTES = 600;
   // watchdog limit, several times over the worst case
   localparam int CYCLE_LIMIT = 400000;
   localparam logic [31:0] CRC32_POLY = 32'h04C1_1DB7;
   // index with no register behind it
   localparam logic [1:0] CSR_UNMAPPED = 2'd3;

   typedef enum bit {
      ROW_BYTE,
      ROW_CSR
   } row_kind_type;

   // one row of the directed table
   typedef struct packed {
      row_kind_type kind;
      logic [1:0]   idx;       // register, CSR rows only
      logic [31:0]  value;     // data byte or register value
      logic         last;      // final byte of the image
      bit           typed;     // expected result given below
      logic [31:0]  crc;
      logic         is_match;
   } stim_row_type;

   typedef struct packed {
      logic [CRC_W-1:0] crc;
      logic             is_match;
   } crc_result_type;

   typedef struct packed {
      logic [CRC_W-1:0]   crc;
      logic [BLOCK_W-1:0] count;     // bytes taken in the current block
      bit                 started;   // current image has taken a byte
   } crc_state_type;

   typedef struct packed {
      logic [BLOCK_W-1:0] block_size;
      logic [CRC_W-1:0]   expected;
      logic [CRC_W-1:0]   start;
   } csr_shadow_type;

   typedef struct packed {
      crc_state_type  next;
      bit             emits;
      crc_result_type res;
   } step_out_type;

   // Directed table. Rows with typed set carry a result that is obvious:
   // a single zero byte from a zero start value just gets inverted once.
   localparam stim_row_type DIRECTED_ROWS [28] = '{
      // after reset: block 512, expected 0, start 0
      '{ROW_BYTE, CSR_UNMAPPED,   32'h0000_0000, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b0},
      '{ROW_CSR,  CSR_EXPECTED,   32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0,         1'b0},
      '{ROW_BYTE, CSR_UNMAPPED,   32'h0000_0000, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b1},
      // zero block size acts as one; final byte closing a block inverts once
      '{ROW_CSR,  CSR_BLOCK_SIZE, 32'h0000_0000, 1'b0, 1'b0, 32'h0,         1'b0},
      '{ROW_BYTE, CSR_UNMAPPED,   32'h0000_0000, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b1},
      '{ROW_BYTE, CSR_UNMAPPED,   32'h0000_00FF, 1'b0, 1'b0, 32'h0,         1'b0},
      '{ROW_BYTE, CSR_UNMAPPED,   32'h0000_0080, 1'b0, 1'b0, 32'h0,         1'b0},
      '{ROW_BYTE, CSR_UNMAPPED,   32'h0000_0001, 1'b1, 1'b0, 32'h0,         1'b0},
      // start value between images loads the register at once
      '{ROW_CSR,  CSR_START,      32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0,         1'b0},
      '{ROW_CSR,  CSR_BLOCK_SIZE, 32'h0000_0003, 1'b0, 1'b0, 32'h0,         1'b0},
      '{ROW_BYTE, CSR_UNMAPPED,   32'h0000_00FF, 1'b0, 1'b0, 32'h0,         1'b0},
      '{ROW_BYTE, CSR_UNMAPPED,   32'h0000_0000, 1'b0, 1'b0, 32'h0,         1'b0},
      '{ROW_BYTE, CSR_UNMAPPED,   32'h0000_0055, 1'b0, 1'b0, 32'h0,         1'b0},
      '{ROW_BYTE, CSR_UNMAPPED,   32'h0000_00AA, 1'b1, 1'b0, 32'h0,         1'b0},
      // start value written mid-image only applies to the next image
      '{ROW_BYTE, CSR_UNMAPPED,   32'h0000_0012, 1'b0, 1'b0, 32'h0,         1'b0},
      '{ROW_CSR,  CSR_START,      32'h0000_0000, 1'b0, 1'b0, 32'h0,         1'b0},
      '{ROW_BYTE, CSR_UNMAPPED,   32'h0000_0034, 1'b1, 1'b0, 32'h0,         1'b0},
      '{ROW_BYTE, CSR_UNMAPPED,   32'h0000_0000, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b1},
      // block size shrunk below the running count: block ends on next byte
      '{ROW_CSR,  CSR_BLOCK_SIZE, 32'h0000_0008, 1'b0, 1'b0, 32'h0,         1'b0},
      '{ROW_BYTE, CSR_UNMAPPED,   32'h0000_0001, 1'b0, 1'b0, 32'h0,         1'b0},
      '{ROW_BYTE, CSR_UNMAPPED,   32'h0000_0002, 1'b0, 1'b0, 32'h0,         1'b0},
      '{ROW_BYTE, CSR_UNMAPPED,   32'h0000_0003, 1'b0, 1'b0, 32'h0,         1'b0},
      '{ROW_CSR,  CSR_BLOCK_SIZE, 32'h0000_0002, 1'b0, 1'b0, 32'h0,         1'b0},
      '{ROW_BYTE, CSR_UNMAPPED,   32'h0000_0004, 1'b0, 1'b0, 32'h0,         1'b0},
      '{ROW_BYTE, CSR_UNMAPPED,   32'h0000_0005, 1'b1, 1'b0, 32'h0,         1'b0},
      // unmapped index must leave every register alone
      '{ROW_CSR,  CSR_UNMAPPED,   32'hDEAD_BEEF, 1'b0, 1'b0, 32'h0,         1'b0},
      '{ROW_BYTE, CSR_UNMAPPED,   32'h0000_0000, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b1},
      // oversized block size with junk above bit 12: clamps to MAX_BLOCK
      '{ROW_CSR,  CSR_BLOCK_SIZE, 32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0,         1'b0}
   };

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;     // [7:0] data_byte
   logic        req_tlast;     // final_byte
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;     // [31:0] crc_value
   logic [0:0]  rsp_tuser;     // [0] crc_matches
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [31:0] csr_data;

   // predictor state, updated on every accepted transaction
   crc_state_type  img_state;
   csr_shadow_type csr_shadow;
   crc_result_type pending_crcs[$];

   bit burst_mode;           // no idling on either side while set
   int cycle_count = 0;
   int mismatch_count = 0;
   int bytes_sent = 0;
   int results_checked = 0;
   int matches_seen = 0;
   int csr_writes = 0;

   blockwise_crc32_check i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // Fold one byte MSB first, then handle block end and image end.
   function automatic step_out_type crc_advance(crc_state_type s, logic [7:0] d, logic l);
      step_out_type o;
      logic [BLOCK_W-1:0] lim;
      logic fb;
      int i;
      lim = csr_shadow.block_size;
      if (lim == '0) begin
         lim = 13'd1;
      end else if (lim > BLOCK_MAX) begin
         lim = BLOCK_MAX;
      end
      for (i = 7; i >= 0; i--) begin
         fb = s.crc[31] ^ d[i];
         s.crc = {s.crc[30:0], 1'b0} ^ (fb ? CRC32_POLY : 32'd0);
      end
      s.started = 1'b1;
      s.count = s.count + 13'd1;
      // block end and image end together invert only once
      if (s.count >= lim || l) begin
         s.crc = ~s.crc;
         s.count = '0;
      end
      o.emits = l;
      o.res.crc = s.crc;
      o.res.is_match = (s.crc == csr_shadow.expected);
      if (l) begin
         s.crc = csr_shadow.start;
         s.count = '0;
         s.started = 1'b0;
      end
      o.next = s;
      return o;
   endfunction

   task automatic note_mismatch(input string what, input logic [31:0] want,
                                input logic [31:0] got);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("mismatch @%0d: %s expected %h got %h", cycle_count, what, want, got);
      end
   endtask

   // Present one byte, hold it until accepted, then run the predictor.
   // Valid stays high on return so back-to-back bytes need no extra edge.
   task automatic send_byte(input logic [7:0] d, input logic l, input bit typed,
                            input logic [31:0] t_crc, input logic t_match);
      step_out_type so;
      crc_result_type r;
      while (!burst_mode && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= d;
      req_tlast <= l;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      so = crc_advance(img_state, d, l);
      img_state = so.next;
      bytes_sent++;
      if (so.emits) begin
         r = so.res;
         if (typed) begin
            r.crc = t_crc;
            r.is_match = t_match;
         end
         pending_crcs.push_back(r);
      end
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [31:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_writes++;
      case (idx)
         CSR_BLOCK_SIZE: csr_shadow.block_size = val[BLOCK_W-1:0];
         CSR_EXPECTED:   csr_shadow.expected = val;
         CSR_START: begin
            csr_shadow.start = val;
            // between images the new start value is loaded right away
            if (!img_state.started) img_state.crc = val;
         end
         default: ;
      endcase
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Drop valid, wait for every pending result, then let the engine finish
   // any trailing non-final bytes before touching registers.
   task automatic drain_and_settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_crcs.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Response side: random backpressure outside burst mode, field-by-field compare.
   always @(posedge clock) begin
      crc_result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= burst_mode || ($urandom_range(99) >= IDLE_PCT);
         if (rsp_tvalid && rsp_tready) begin
            if (pending_crcs.size() == 0) begin
               note_mismatch("response with nothing pending", 32'd0, rsp_tdata);
            end else begin
               want = pending_crcs.pop_front();
               if (rsp_tdata !== want.crc) begin
                  note_mismatch("crc_value", want.crc, rsp_tdata);
               end
               if (rsp_tuser[0] !== want.is_match) begin
                  note_mismatch("crc_matches", {31'd0, want.is_match}, {31'd0, rsp_tuser[0]});
               end
               results_checked++;
               if (rsp_tuser[0] === 1'b1) matches_seen++;
            end
         end
      end
   end

   // Watchdog: a hang anywhere ends here.
   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("timeout after %0d cycles, %0d results pending", cycle_count,
               pending_crcs.size());
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      stim_row_type row;
      logic [7:0] plan_data[$];
      bit plan_last[$];
      crc_state_type probe;
      step_out_type so;
      logic [31:0] val;
      int random_bytes;
      int n_images;
      int len;
      int i;
      int k;

      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      req_tlast <= 1'b0;
      csr_valid <= 1'b0;
      csr_index <= '0;
      csr_data <= '0;
      burst_mode = 1'b0;
      csr_shadow.block_size = BLOCK_SIZE_RESET;
      csr_shadow.expected = '0;
      csr_shadow.start = '0;
      img_state = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // ---- directed table ----
      for (i = 0; i < 28; i++) begin
         row = DIRECTED_ROWS[i];
         if (row.kind == ROW_CSR) begin
            drain_and_settle();
            write_csr(row.idx, row.value);
         end else begin
            send_byte(row.value[7:0], row.last, row.typed, row.crc, row.is_match);
         end
      end

      // ---- one long image under the clamped block size ----
      drain_and_settle();
      write_csr(CSR_EXPECTED, $urandom());
      for (i = 0; i < LONG_IMAGE_BYTES; i++) begin
         send_byte(8'($urandom_range(255)), i == LONG_IMAGE_BYTES - 1, 1'b0, '0, 1'b0);
      end

      // ---- random phases ----
      // Each phase: quiesce, rewrite some registers, then a few images.
      // Some phases leave an image open so the next phase's writes land
      // mid-image.
      random_bytes = 0;
      while (random_bytes < RANDOM_BYTES) begin
         drain_and_settle();
         if ($urandom_range(1) == 1) begin
            k = $urandom_range(9);
            if (k == 0) begin
               val = 32'd0;
            end else if (k == 1) begin
               val = $urandom_range(MAX_BLOCK, 8191);
            end else if (k == 2) begin
               val = $urandom_range(13, 64);
            end else begin
               val = $urandom_range(1, 12);
            end
            // bits above the field must be dropped
            if ($urandom_range(3) == 0) val = val | ($urandom() & 32'hFFFF_E000);
            write_csr(CSR_BLOCK_SIZE, val);
         end
         if ($urandom_range(2) == 0) write_csr(CSR_START, $urandom());

         plan_data.delete();
         plan_last.delete();
         n_images = $urandom_range(1, 5);
         repeat (n_images) begin
            len = ($urandom_range(99) < 15) ? $urandom_range(17, 48) : $urandom_range(1, 16);
            for (i = 0; i < len; i++) begin
               plan_data.push_back(8'($urandom_range(255)));
               plan_last.push_back(i == len - 1);
            end
         end
         if ($urandom_range(9) < 3) begin
            repeat ($urandom_range(1, 6)) begin
               plan_data.push_back(8'($urandom_range(255)));
               plan_last.push_back(1'b0);
            end
         end

         // half the time aim expected_crc at the phase's first image
         if ($urandom_range(1) == 1) begin
            probe = img_state;
            for (i = 0; i < plan_data.size(); i++) begin
               so = crc_advance(probe, plan_data[i], plan_last[i]);
               probe = so.next;
               if (so.emits) break;
            end
            write_csr(CSR_EXPECTED, so.res.crc);
         end else if ($urandom_range(1) == 1) begin
            write_csr(CSR_EXPECTED, $urandom());
         end

         for (i = 0; i < plan_data.size(); i++) begin
            burst_mode = (random_bytes >= 150 && random_bytes < 350);
            send_byte(plan_data[i], plan_last[i], 1'b0, '0, 1'b0);
            random_bytes++;
         end
      end

      // close any image left open so its result is checked too
      burst_mode = 1'b0;
      send_byte(8'($urandom_range(255)), 1'b1, 1'b0, '0, 1'b0);
      drain_and_settle();

      $display("checked %0d results (%0d flagged matching) over %0d bytes, %0d register writes",
               results_checked, matches_seen, bytes_sent, csr_writes);
      $display("block sizes zero to oversized, mid-image writes, one %0d-byte image",
               LONG_IMAGE_BYTES);
      if (mismatch_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/bcc_pkg.sv
hw/rtl/bcc_front.sv
hw/rtl/bcc_back.sv
hw/rtl/blockwise_crc32_check.sv
verif/blockwise_crc32_check_tb.sv
